/* rtl/dmc_pkg.sv */
// dmc_pkg: shared types and constants of the direct-mapped write-through cache
// holds the state machine encoding, controller/datapath handshake structs and counter slots
// depends on nothing
`timescale 1ns / 1ps

package dmc_pkg;

	// fixed payload widths
	localparam int DATA_W  = 8;
	localparam int CNT_W   = 32;
	localparam int NUM_CNT = 9;

	// result beat: rdata, hit, nine counters, zero fill up to whole bytes
	localparam int OUT_RAW_W = DATA_W + 1 + NUM_CNT * CNT_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
	localparam int CNT_LSB   = DATA_W + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// statistics counter slots
	localparam int CNT_ACCESS = 0;
	localparam int CNT_HIT    = 1;
	localparam int CNT_MISS   = 2;
	localparam int CNT_READ   = 3;
	localparam int CNT_WRITE  = 4;
	localparam int CNT_RHIT   = 5;
	localparam int CNT_WHIT   = 6;
	localparam int CNT_RMISS  = 7;
	localparam int CNT_WMISS  = 8;

	typedef logic [CNT_W-1:0] cnt_t;

	// access kind carried on tuser
	typedef enum logic {
		ACC_READ  = 1'b0,
		ACC_WRITE = 1'b1
	} acc_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_CHECK,
		ST_FILL,
		ST_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic in_ready;
		logic take;
		logic lookup;
		logic check;
		logic fill_step;
		logic respond;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic hit;
		logic fill_done;
	} dp_status_t;

endpackage

/* rtl/dmc_ctrl.sv */
// dmc_ctrl: sequencer of the cache: clearing pass, lookup, check, line fill, response
// depends on dmc_pkg for the state encoding and the command/status structs
`timescale 1ns / 1ps

module dmc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  out_free,
	input  dmc_pkg::dp_status_t   status,
	output dmc_pkg::dp_cmd_t      cmd
);

	dmc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmc_pkg::ST_CLEAR: begin
				if (status.clr_done) state_d = dmc_pkg::ST_IDLE;
			end
			dmc_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = dmc_pkg::ST_LOOKUP;
			end
			dmc_pkg::ST_LOOKUP: begin
				state_d = dmc_pkg::ST_CHECK;
			end
			dmc_pkg::ST_CHECK: begin
				state_d = status.hit ? dmc_pkg::ST_RESP : dmc_pkg::ST_FILL;
			end
			dmc_pkg::ST_FILL: begin
				if (status.fill_done) state_d = dmc_pkg::ST_RESP;
			end
			dmc_pkg::ST_RESP: begin
				if (out_free) state_d = dmc_pkg::ST_IDLE;
			end
			default: begin
				state_d = dmc_pkg::ST_CLEAR;
			end
		endcase
	end

	// command strobes
	always_comb begin
		cmd = '0;
		case (state_q)
			dmc_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			dmc_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.take     = s_tvalid;
			end
			dmc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
			end
			dmc_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
			end
			dmc_pkg::ST_FILL: begin
				cmd.fill_step = 1'b1;
			end
			dmc_pkg::ST_RESP: begin
				cmd.respond = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/dmc_dpath.sv */
// dmc_dpath: address split, tag store, line store and backing memory of the cache
// depends on dmc_pkg; driven by dmc_ctrl through dp_cmd_t, reports through dp_status_t
`timescale 1ns / 1ps

module dmc_dpath #(
	parameter int ADDR_BITS      = 8,
	parameter int NUM_LINES      = 16,
	parameter int WORDS_PER_LINE = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dmc_pkg::dp_cmd_t            cmd,
	input  logic                        in_write,
	input  logic [ADDR_BITS-1:0]        in_addr,
	input  logic [dmc_pkg::DATA_W-1:0]  in_wdata,
	output dmc_pkg::dp_status_t         status,
	output logic [dmc_pkg::DATA_W-1:0]  rdata,
	output logic                        hit,
	output logic                        is_write
);

	localparam int MEM_SIZE   = 1 << ADDR_BITS;
	localparam int LINE_BYTES = NUM_LINES * WORDS_PER_LINE;
	localparam int LINE_W     = $clog2(NUM_LINES);
	localparam int OFF_W      = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
	localparam int CIDX_W     = $clog2(LINE_BYTES);
	localparam int NUM_TAGS   = (MEM_SIZE - 1) / LINE_BYTES + 1;
	localparam int TAG_W      = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
	localparam int FILL_W     = $clog2(WORDS_PER_LINE + 1);
	localparam int CLR_N      = (MEM_SIZE > NUM_LINES) ? MEM_SIZE : NUM_LINES;
	localparam int CLR_W      = $clog2(CLR_N);
	localparam int XW         = ADDR_BITS + CIDX_W;
	// reciprocal multipliers, exact for every address below 2^ADDR_BITS
	localparam int MW         = ADDR_BITS + 2;
	localparam int PW         = ADDR_BITS + MW;
	localparam int SH_W       = ADDR_BITS + $clog2(WORDS_PER_LINE);
	localparam int SH_T       = ADDR_BITS + $clog2(LINE_BYTES);
	localparam longint unsigned RCP_W =
		((64'd1 << SH_W) + WORDS_PER_LINE - 1) / WORDS_PER_LINE;
	localparam longint unsigned RCP_T =
		((64'd1 << SH_T) + LINE_BYTES - 1) / LINE_BYTES;

	// captured access
	logic [ADDR_BITS-1:0]       addr_q;
	logic [dmc_pkg::DATA_W-1:0] wdata_q;
	logic                       write_q;
	logic [ADDR_BITS-1:0]       word_q;
	logic [TAG_W-1:0]           tag_q;

	// split address
	logic [LINE_W-1:0]    line_q;
	logic [CIDX_W-1:0]    cidx_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [OFF_W-1:0]     off_q;

	// memories and their read registers
	logic [TAG_W:0]             tag_mem [NUM_LINES];
	logic [dmc_pkg::DATA_W-1:0] line_mem [LINE_BYTES];
	logic [dmc_pkg::DATA_W-1:0] back_mem [MEM_SIZE];
	logic [TAG_W:0]             tag_rd_q;
	logic [dmc_pkg::DATA_W-1:0] cbyte_q;
	logic [dmc_pkg::DATA_W-1:0] mem_rd_q;

	logic [dmc_pkg::DATA_W-1:0] rdata_q;
	logic                       hit_q;
	logic [FILL_W-1:0]          fill_q;
	logic [CLR_W-1:0]           clr_q;

	logic [PW-1:0]     prod_w, prod_t, quo_w, quo_t;
	logic [XW-1:0]     base_x, off_x, line_x, cidx_x;
	logic              hit_c;
	logic              clr_done, clr_in_mem, clr_in_tags;
	logic              fill_done, fill_rd, fill_wr, tag_wr, mem_wr;
	logic [FILL_W-1:0] fill_m1;
	logic [CIDX_W-1:0] fill_idx;

	// word and tag number by reciprocal multiplication of the incoming address
	always_comb begin
		prod_w = PW'(in_addr) * PW'(RCP_W);
		prod_t = PW'(in_addr) * PW'(RCP_T);
		quo_w  = prod_w >> SH_W;
		quo_t  = prod_t >> SH_T;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			addr_q  <= in_addr;
			wdata_q <= in_wdata;
			write_q <= in_write;
			word_q  <= quo_w[ADDR_BITS-1:0];
			tag_q   <= quo_t[TAG_W-1:0];
		end
	end

	// offset, line, line base and line store index by constant products
	always_comb begin
		base_x = XW'(word_q) * XW'(WORDS_PER_LINE);
		off_x  = XW'(addr_q) - base_x;
		line_x = XW'(word_q) - XW'(tag_q) * XW'(NUM_LINES);
		cidx_x = XW'(addr_q) - XW'(tag_q) * XW'(LINE_BYTES);
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			line_q <= line_x[LINE_W-1:0];
			cidx_q <= cidx_x[CIDX_W-1:0];
			base_q <= base_x[ADDR_BITS-1:0];
			off_q  <= off_x[OFF_W-1:0];
		end
	end

	// clearing pass over backing memory and tag store after reset
	assign clr_done    = (clr_q == CLR_W'(CLR_N - 1));
	assign clr_in_mem  = ({1'b0, clr_q} < (CLR_W + 1)'(MEM_SIZE));
	assign clr_in_tags = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_LINES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step && !clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// line fill sequencing: read word k, write word k-1
	assign fill_done = (fill_q == FILL_W'(WORDS_PER_LINE));
	assign fill_rd   = cmd.fill_step && (fill_q < FILL_W'(WORDS_PER_LINE));
	assign fill_wr   = cmd.fill_step && (fill_q != '0);
	assign fill_m1   = fill_q - 1'b1;
	assign fill_idx  = cidx_q - CIDX_W'(off_q) + CIDX_W'(fill_m1);
	assign tag_wr    = cmd.fill_step && fill_done;
	assign mem_wr    = cmd.check && write_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.fill_step) begin
			fill_q <= fill_done ? '0 : fill_q + 1'b1;
		end
	end

	// tag store: valid bit over tag
	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_in_tags) begin
			tag_mem[clr_q[LINE_W-1:0]] <= '0;
		end else if (tag_wr) begin
			tag_mem[line_q] <= {1'b1, tag_q};
		end
		if (cmd.lookup) begin
			tag_rd_q <= tag_mem[line_x[LINE_W-1:0]];
		end
	end

	assign hit_c = tag_rd_q[TAG_W] && (tag_rd_q[TAG_W-1:0] == tag_q);

	// backing memory, written through on every write
	always_ff @(posedge clk) begin
		if (cmd.clr_step && clr_in_mem) begin
			back_mem[clr_q[ADDR_BITS-1:0]] <= '0;
		end else if (mem_wr) begin
			back_mem[addr_q] <= wdata_q;
		end
		if (fill_rd) begin
			mem_rd_q <= back_mem[base_q + ADDR_BITS'(fill_q)];
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (fill_wr) begin
			line_mem[fill_idx] <= mem_rd_q;
		end else if (mem_wr && hit_c) begin
			line_mem[cidx_q] <= wdata_q;
		end
		if (cmd.lookup) begin
			cbyte_q <= line_mem[cidx_x[CIDX_W-1:0]];
		end
	end

	// result byte and hit flag
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			hit_q   <= hit_c;
			rdata_q <= write_q ? wdata_q : cbyte_q;
		end else if (fill_wr && (fill_m1 == FILL_W'(off_q))) begin
			rdata_q <= mem_rd_q;
		end
	end

	always_comb begin
		status.clr_done  = clr_done;
		status.hit       = hit_c;
		status.fill_done = fill_done;
	end

	assign rdata    = rdata_q;
	assign hit      = hit_q;
	assign is_write = write_q;

endmodule

/* rtl/dmc_resp.sv */
// dmc_resp: statistics counters and the result register of the cache
// depends on dmc_pkg for counter slots and the result beat layout
`timescale 1ns / 1ps

module dmc_resp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        respond,
	input  logic                        hit,
	input  logic                        is_write,
	input  logic [dmc_pkg::DATA_W-1:0]  rdata,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [dmc_pkg::OUT_W-1:0]   m_tdata,
	output logic                        out_free
);

	dmc_pkg::cnt_t              cnt_q [dmc_pkg::NUM_CNT];
	dmc_pkg::cnt_t              cnt_d [dmc_pkg::NUM_CNT];
	logic [dmc_pkg::NUM_CNT-1:0] inc;
	logic                       valid_q;
	logic                       hit_q;
	logic [dmc_pkg::DATA_W-1:0] rdata_q;

	assign out_free = !valid_q || m_tready;

	// which counters this access bumps
	always_comb begin
		inc                       = '0;
		inc[dmc_pkg::CNT_ACCESS]  = 1'b1;
		inc[dmc_pkg::CNT_HIT]     = hit;
		inc[dmc_pkg::CNT_MISS]    = !hit;
		inc[dmc_pkg::CNT_READ]    = !is_write;
		inc[dmc_pkg::CNT_WRITE]   = is_write;
		inc[dmc_pkg::CNT_RHIT]    = !is_write && hit;
		inc[dmc_pkg::CNT_WHIT]    = is_write && hit;
		inc[dmc_pkg::CNT_RMISS]   = !is_write && !hit;
		inc[dmc_pkg::CNT_WMISS]   = is_write && !hit;
	end

	// saturating increments
	always_comb begin
		for (int i = 0; i < dmc_pkg::NUM_CNT; i++) begin
			cnt_d[i] = (inc[i] && (cnt_q[i] != dmc_pkg::CNT_MAX)) ? cnt_q[i] + 1'b1 : cnt_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dmc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (respond) begin
			for (int i = 0; i < dmc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= cnt_d[i];
			end
		end
	end

	// result beat holding register; counters only move when a new beat loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (respond) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (respond) begin
			hit_q   <= hit;
			rdata_q <= rdata;
		end
	end

	// pack rdata, hit, then the counters from the lowest bit up
	always_comb begin
		m_tdata                       = '0;
		m_tdata[dmc_pkg::DATA_W-1:0]  = rdata_q;
		m_tdata[dmc_pkg::DATA_W]      = hit_q;
		for (int i = 0; i < dmc_pkg::NUM_CNT; i++) begin
			m_tdata[dmc_pkg::CNT_LSB + i * dmc_pkg::CNT_W +: dmc_pkg::CNT_W] = cnt_q[i];
		end
	end

	assign m_tvalid = valid_q;

endmodule

/* rtl/direct_mapped_cache_write_through_top.sv */
// direct_mapped_cache_write_through_top: direct-mapped write-through, write-allocate cache
// depends on dmc_pkg, dmc_ctrl, dmc_dpath and dmc_resp
`timescale 1ns / 1ps

// Usage
// One access beat in on the s_ stream (tuser = kind, 0 read / 1 write; tdata = addr, wdata),
// one result beat out on the m_ stream for every access: the byte at the address after the
// access, the hit flag and nine saturating statistics counters.
// Writes go through to the backing memory; a miss of either kind fills the whole line
// from the backing memory (a write miss after the memory update).
// An access goes from acceptance through lookup, check and response to m_tvalid; a miss adds
// the line fill before the response (one backing memory port, one byte per cycle).
// Accesses are taken one at a time: s_tready is high only in the idle step, so the
// lookup/check sequence and the single-port line fill end before the next is accepted.
// Reset: after arst_n rises the block clears the backing memory and the valid marks,
// one entry per step over the larger of 2^ADDR_BITS and NUM_LINES, with s_tready low.
// Stall: a finished result waits in the output register while the next access is
// accepted and looked up; the block then holds in its response step until m_tready.
module direct_mapped_cache_write_through_top #(
	parameter int ADDR_BITS      = 8,
	parameter int NUM_LINES      = 16,
	parameter int WORDS_PER_LINE = 4
) (
	input  logic clk,
	input  logic arst_n,
	// access channel
	input  logic s_tvalid,
	output logic s_tready,
	// addr, wdata, zero fill
	input  logic [((ADDR_BITS + dmc_pkg::DATA_W + 7) / 8) * 8 - 1:0] s_tdata,
	// cmd
	input  logic s_tuser,
	// result channel
	output logic m_tvalid,
	input  logic m_tready,
	// rdata, hit, access_count, hit_count, miss_count, read_count, write_count,
	// read_hit_count, write_hit_count, read_miss_count, write_miss_count, zero fill
	output logic [dmc_pkg::OUT_W-1:0] m_tdata
);

	dmc_pkg::dp_cmd_t           cmd;
	dmc_pkg::dp_status_t        status;
	logic                       out_free;
	logic                       in_write;
	logic [dmc_pkg::DATA_W-1:0] rdata;
	logic                       hit;
	logic                       is_write;

	assign s_tready = cmd.in_ready;
	assign in_write = (s_tuser == dmc_pkg::ACC_WRITE);

	dmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd)
	);

	dmc_dpath #(
		.ADDR_BITS      (ADDR_BITS),
		.NUM_LINES      (NUM_LINES),
		.WORDS_PER_LINE (WORDS_PER_LINE)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_write (in_write),
		.in_addr  (s_tdata[ADDR_BITS-1:0]),
		.in_wdata (s_tdata[ADDR_BITS +: dmc_pkg::DATA_W]),
		.status   (status),
		.rdata    (rdata),
		.hit      (hit),
		.is_write (is_write)
	);

	dmc_resp u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.respond  (cmd.respond),
		.hit      (hit),
		.is_write (is_write),
		.rdata    (rdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.out_free (out_free)
	);

endmodule

/* rtl/dmc_checker.sv */
// dmc_checker: port-level checks on the cache top level, attached by bind
// depends on dmc_pkg for the result beat layout and on direct_mapped_cache_write_through_top
`timescale 1ns / 1ps

module dmc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [dmc_pkg::OUT_W-1:0] m_tdata
);

	localparam int CW = dmc_pkg::CNT_W;
	localparam int LB = dmc_pkg::CNT_LSB;

	logic           res_hit;
	logic [CW-1:0]  n_access, n_hit, n_miss, n_read, n_write;

	// result beat fields
	assign res_hit  = m_tdata[dmc_pkg::DATA_W];
	assign n_access = m_tdata[LB + dmc_pkg::CNT_ACCESS * CW +: CW];
	assign n_hit    = m_tdata[LB + dmc_pkg::CNT_HIT * CW +: CW];
	assign n_miss   = m_tdata[LB + dmc_pkg::CNT_MISS * CW +: CW];
	assign n_read   = m_tdata[LB + dmc_pkg::CNT_READ * CW +: CW];
	assign n_write  = m_tdata[LB + dmc_pkg::CNT_WRITE * CW +: CW];

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// one access at a time: ready drops after an accepted beat
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second access taken while one is in flight");

	// every access is either a hit or a miss
	a_hm: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (n_access != dmc_pkg::CNT_MAX) |->
			({1'b0, n_hit} + {1'b0, n_miss}) == {1'b0, n_access})
		else $error("hit and miss counts do not add up");

	// every access is either a read or a write
	a_rw: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (n_access != dmc_pkg::CNT_MAX) |->
			({1'b0, n_read} + {1'b0, n_write}) == {1'b0, n_access})
		else $error("read and write counts do not add up");

	// the flag of a beat is counted in its own beat
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_hit && (n_hit != '0)) || (!res_hit && (n_miss != '0)))
		else $error("hit flag not reflected in counters");

endmodule

bind direct_mapped_cache_write_through_top dmc_checker u_dmc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

/* sim/direct_mapped_cache_write_through_top_tb.sv */
// direct_mapped_cache_write_through_top_tb: self-checking bench for the write-through cache
// predicts every result beat from its own copy of tags, lines, memory and counters
// depends on dmc_pkg and direct_mapped_cache_write_through_top
`timescale 1ns / 1ps

module direct_mapped_cache_write_through_top_tb;
	import dmc_pkg::*;

	localparam int ADDR_BITS      = 8;
	localparam int NUM_LINES      = 16;
	localparam int WORDS_PER_LINE = 4;
	localparam int MEM_BYTES      = 1 << ADDR_BITS;
	localparam int IN_W           = ((ADDR_BITS + DATA_W + 7) / 8) * 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int HOT_SLOTS      = 8;

	// one result beat, lowest field in the lowest bits
	typedef struct packed {
		cnt_t [NUM_CNT-1:0] cnt;
		logic               hit;
		logic [DATA_W-1:0]  rdata;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	// predicted cache contents
	logic [1:0]        tag_of [NUM_LINES];
	logic              valid_of [NUM_LINES];
	logic [DATA_W-1:0] line_data [NUM_LINES * WORDS_PER_LINE];
	logic [DATA_W-1:0] backing_mem [MEM_BYTES];
	cnt_t              stat_cnt [NUM_CNT];

	outcome_t outcome_q [$];
	int       fail_count;
	int       cycle_cnt;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       hold_left;
	logic     s_fire;
	logic [7:0] hot_addr [HOT_SLOTS];

	direct_mapped_cache_write_through_top #(
		.ADDR_BITS(ADDR_BITS),
		.NUM_LINES(NUM_LINES),
		.WORDS_PER_LINE(WORDS_PER_LINE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// saturating counter step
	function automatic void bump_stat(int k);
		if (stat_cnt[k] != CNT_MAX)
			stat_cnt[k] = stat_cnt[k] + 1;
	endfunction

	// apply one access to the predicted cache and return the beat it causes
	function automatic outcome_t access_outcome(acc_t kind, logic [7:0] addr,
			logic [DATA_W-1:0] wdata);
		outcome_t   res;
		logic [1:0] offs;
		logic [3:0] line;
		logic [1:0] tag;
		logic       is_hit;
		int         w;
		offs   = addr[1:0];
		line   = addr[5:2];
		tag    = addr[7:6];
		is_hit = valid_of[line] && tag_of[line] == tag;
		bump_stat(CNT_ACCESS);
		bump_stat(is_hit ? CNT_HIT : CNT_MISS);
		if (kind == ACC_WRITE) begin
			bump_stat(CNT_WRITE);
			bump_stat(is_hit ? CNT_WHIT : CNT_WMISS);
			backing_mem[addr] = wdata;
			if (is_hit)
				line_data[line * WORDS_PER_LINE + offs] = wdata;
		end else begin
			bump_stat(CNT_READ);
			bump_stat(is_hit ? CNT_RHIT : CNT_RMISS);
		end
		// allocate on a miss of either kind, after the memory update
		if (!is_hit) begin
			for (w = 0; w < WORDS_PER_LINE; w++)
				line_data[line * WORDS_PER_LINE + w] = backing_mem[{addr[7:2], 2'b00} + w];
			tag_of[line]   = tag;
			valid_of[line] = 1'b1;
		end
		res.rdata = line_data[line * WORDS_PER_LINE + offs];
		res.hit   = is_hit;
		for (w = 0; w < NUM_CNT; w++)
			res.cnt[w] = stat_cnt[w];
		return res;
	endfunction

	function automatic string cnt_name(int k);
		case (k)
			CNT_ACCESS: return "access_count";
			CNT_HIT:    return "hit_count";
			CNT_MISS:   return "miss_count";
			CNT_READ:   return "read_count";
			CNT_WRITE:  return "write_count";
			CNT_RHIT:   return "read_hit_count";
			CNT_WHIT:   return "write_hit_count";
			CNT_RMISS:  return "read_miss_count";
			CNT_WMISS:  return "write_miss_count";
			default:    return "counter";
		endcase
	endfunction

	// check result beats against the oldest prediction, then predict new access beats
	always @(posedge clk) begin : beat_check
		outcome_t want;
		outcome_t got;
		int k;
		if (arst_n) begin
			s_fire <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(outcome_t)-1:0];
				if (outcome_q.size() == 0) begin
					$error("result beat with no access waiting");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (got.rdata !== want.rdata) begin
						$error("rdata expected %0h actual %0h", want.rdata, got.rdata);
						fail_count++;
					end
					if (got.hit !== want.hit) begin
						$error("hit expected %0h actual %0h", want.hit, got.hit);
						fail_count++;
					end
					for (k = 0; k < NUM_CNT; k++)
						if (got.cnt[k] !== want.cnt[k]) begin
							$error("%s expected %0d actual %0d", cnt_name(k),
								want.cnt[k], got.cnt[k]);
							fail_count++;
						end
				end
			end
			if (s_tvalid && s_tready)
				outcome_q.push_back(access_outcome(acc_t'(s_tuser), s_tdata[7:0],
					s_tdata[15:8]));
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// offer one access beat, called at a falling edge, returns at the falling edge after it
	task automatic send_access(acc_t kind, logic [7:0] addr, logic [DATA_W-1:0] wdata);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {wdata, addr};
		do
			@(negedge clk);
		while (!s_fire);
	endtask

	// extremes, every access kind, hits, misses, conflicts and write-after-fill
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_access(ACC_READ,  8'h00, 8'h00);
		send_access(ACC_READ,  8'h00, 8'hFF);
		send_access(ACC_WRITE, 8'h03, 8'hFF);
		send_access(ACC_READ,  8'h03, 8'h00);
		send_access(ACC_WRITE, 8'hFF, 8'hA5);
		send_access(ACC_READ,  8'hFC, 8'h00);
		send_access(ACC_READ,  8'hFF, 8'h00);
		// same line, other tag: eviction and refill from memory
		send_access(ACC_READ,  8'h40, 8'h00);
		send_access(ACC_READ,  8'h03, 8'h00);
		send_access(ACC_WRITE, 8'h80, 8'h00);
		send_access(ACC_WRITE, 8'hC1, 8'h5A);
		send_access(ACC_READ,  8'hC1, 8'h00);
		send_access(ACC_WRITE, 8'hC1, 8'h00);
		send_access(ACC_READ,  8'h01, 8'h00);
		send_access(ACC_READ,  8'h7F, 8'h00);
		send_access(ACC_WRITE, 8'h7E, 8'h81);
		send_access(ACC_READ,  8'h7F, 8'h00);
		send_access(ACC_READ,  8'h7E, 8'h00);
		send_access(ACC_WRITE, 8'h3A, 8'h7F);
		send_access(ACC_READ,  8'hBA, 8'h00);
		send_access(ACC_READ,  8'h3A, 8'h00);
	endtask

	// random accesses, mostly to a small shifting working set so hits and conflicts occur
	task automatic test_random(int n, int s_pct, int r_pct);
		int i;
		int j;
		logic [7:0] a;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (i = 0; i < n; i++) begin
			if (i % 64 == 0)
				for (j = 0; j < HOT_SLOTS; j++)
					hot_addr[j] = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 99) < 75)
				a = hot_addr[$urandom_range(0, HOT_SLOTS - 1)];
			else
				a = 8'($urandom_range(0, 255));
			send_access($urandom_range(0, 1) ? ACC_WRITE : ACC_READ, a,
				8'($urandom_range(0, 255)));
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 300;
		for (i = 0; i < 40; i++)
			send_access($urandom_range(0, 1) ? ACC_WRITE : ACC_READ,
				{2'($urandom_range(0, 3)), 4'($urandom_range(0, 1)), 2'($urandom_range(0, 3))},
				8'($urandom_range(0, 255)));
	endtask

	initial begin : run
		int k;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		m_tready      = 1'b0;
		s_fire        = 1'b0;
		fail_count    = 0;
		cycle_cnt     = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left     = 0;
		for (k = 0; k < NUM_LINES; k++) begin
			tag_of[k]   = '0;
			valid_of[k] = 1'b0;
		end
		for (k = 0; k < NUM_LINES * WORDS_PER_LINE; k++)
			line_data[k] = '0;
		for (k = 0; k < MEM_BYTES; k++)
			backing_mem[k] = '0;
		for (k = 0; k < NUM_CNT; k++)
			stat_cnt[k] = '0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(450, 23, 65);
		test_random(450, 65, 23);
		test_backpressure();
		test_random(440, 0, 0);
		s_tvalid <= 1'b0;

		// drain, then watch for stray beats
		while (outcome_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (fail_count == 0 && outcome_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
